// ----- sv/assert_macros.svh -----
// Assertion macros shared by the hotplug-detect event queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// Checks that a consequence holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

// ----- sv/hpdq_pkg.sv -----
// Types and constants shared by the hotplug-detect event queue modules.
`timescale 1ns / 1ps

package hpdq_pkg;

  localparam int CFG_W = 20;
  localparam int AGE_W = 24;
  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // Reported event codes.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_LOW  = 2'd1;
  localparam logic [1:0] EV_HIGH = 2'd2;
  localparam logic [1:0] EV_IRQ  = 2'd3;

  // Edge classes produced by the front end.
  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_GLITCH     = 3'd1;
  localparam logic [2:0] KIND_IRQ        = 3'd2;
  localparam logic [2:0] KIND_LONG_LOW   = 3'd3;
  localparam logic [2:0] KIND_FALL_SHORT = 3'd4;
  localparam logic [2:0] KIND_FALL_LONG  = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_GLITCH   = 2'd0;
  localparam logic [1:0] REG_IRQ      = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE = 2'd2;
  localparam logic [1:0] REG_GAP      = 2'd3;

  localparam logic [CFG_W-1:0] GLITCH_RESET   = 20'd150;
  localparam logic [CFG_W-1:0] IRQ_RESET      = 20'd2000;
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 20'd100000;
  localparam logic [CFG_W-1:0] GAP_RESET      = 20'd4000;

  // Command queue between front and back.
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int CMD_CNT_W = 2;

  // Result buffer in the back end.
  localparam int OUT_DEPTH = 3;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 2;

  typedef struct packed {
    logic [CFG_W-1:0] glitch_limit_us;
    logic [CFG_W-1:0] irq_limit_us;
    logic [CFG_W-1:0] level_debounce_us;
    logic [CFG_W-1:0] queue_gap_us;
  } cfg_t;

  typedef struct packed {
    logic       level;
    logic [2:0] kind;
  } cmd_t;

  typedef struct packed {
    logic [1:0] ev;
    logic       from_level;
    logic       last;
  } res_t;

endpackage

// ----- sv/hotplug_detect_event_queue.sv -----
// Top level of the hotplug-detect event queue: configuration registers and wiring.
// The block takes one hotplug-detect pin sample per beat on the input channel, one
// beat per microsecond tick, and sends zero, one or two report beats per sample on
// the result channel, the level-timer report first; last marks the final beat of a
// sample. A sample is accepted every cycle while results drain; the result channel
// moves one beat per cycle while out_stall is low, so samples that yield two reports
// can hold the input back. The front end classifies a sample as it is accepted and
// writes it into a two-entry command queue at that edge; once the result buffer has
// room for two beats, the back end takes the command, applies the ring and timer
// update and writes a three-beat result buffer. A sample's first report thus reaches
// the result port after both the command queue and the result buffer are written.
// Registers sit at byte addresses 0 (glitch limit), 4 (IRQ limit),
// 8 (level debounce) and 12 (queue gap), 20 bits each; write them only while idle.
`timescale 1ns / 1ps

module hotplug_detect_event_queue #(
  parameter int RING_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        hpd_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  report_event,
  output logic        from_level_timer,
  output logic        last
);

  hpdq_pkg::cfg_t cfg;
  logic           cfg_write;
  logic [1:0]     reg_idx;
  logic           cmd_push;
  logic           cmd_full;
  logic           cmd_valid;
  logic           cmd_pop;
  hpdq_pkg::cmd_t cmd_in;
  hpdq_pkg::cmd_t cmd_out;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glitch_limit_us   <= hpdq_pkg::GLITCH_RESET;
      cfg.irq_limit_us      <= hpdq_pkg::IRQ_RESET;
      cfg.level_debounce_us <= hpdq_pkg::DEBOUNCE_RESET;
      cfg.queue_gap_us      <= hpdq_pkg::GAP_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        hpdq_pkg::REG_GLITCH:   cfg.glitch_limit_us   <= pwdata[hpdq_pkg::CFG_W-1:0];
        hpdq_pkg::REG_IRQ:      cfg.irq_limit_us      <= pwdata[hpdq_pkg::CFG_W-1:0];
        hpdq_pkg::REG_DEBOUNCE: cfg.level_debounce_us <= pwdata[hpdq_pkg::CFG_W-1:0];
        hpdq_pkg::REG_GAP:      cfg.queue_gap_us      <= pwdata[hpdq_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hpdq_pkg::REG_GLITCH:   prdata = {12'b0, cfg.glitch_limit_us};
      hpdq_pkg::REG_IRQ:      prdata = {12'b0, cfg.irq_limit_us};
      hpdq_pkg::REG_DEBOUNCE: prdata = {12'b0, cfg.level_debounce_us};
      hpdq_pkg::REG_GAP:      prdata = {12'b0, cfg.queue_gap_us};
      default:                prdata = '0;
    endcase
  end

  hpdq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .hpd_level (hpd_level),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  hpdq_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (cmd_in),
    .full      (cmd_full),
    .pop_valid (cmd_valid),
    .pop_cmd   (cmd_out),
    .pop       (cmd_pop)
  );

  hpdq_back #(
    .RING_SLOTS (RING_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd_out),
    .cmd_pop          (cmd_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .report_event     (report_event),
    .from_level_timer (from_level_timer),
    .last             (last)
  );

endmodule

// ----- sv/hpdq_front.sv -----
// Front end: takes pin samples, times edges and classifies each edge.
`timescale 1ns / 1ps

module hpdq_front (
  input  logic                clk,
  input  logic                rst,
  input  hpdq_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                hpd_level,
  input  logic                cmd_full,
  output logic                cmd_push,
  output hpdq_pkg::cmd_t      cmd
);

  logic                       started;
  logic                       prev_level;
  logic [hpdq_pkg::AGE_W-1:0] edge_age;
  logic [hpdq_pkg::AGE_W-1:0] age;
  logic                       accept;
  logic                       is_edge;
  logic [2:0]                 kind;

  assign in_stall = cmd_full;
  assign accept   = in_valid && !cmd_full;
  assign age      = (edge_age == hpdq_pkg::AGE_MAX) ? hpdq_pkg::AGE_MAX
                                                    : edge_age + 1'b1;
  assign is_edge  = hpd_level != prev_level;

  always_comb begin
    kind = hpdq_pkg::KIND_NONE;
    if (is_edge) begin
      if (hpd_level) begin
        if (age <= {4'b0, cfg.glitch_limit_us}) begin
          kind = hpdq_pkg::KIND_GLITCH;
        end else if (age <= {4'b0, cfg.irq_limit_us}) begin
          kind = hpdq_pkg::KIND_IRQ;
        end else begin
          kind = hpdq_pkg::KIND_LONG_LOW;
        end
      end else if (age > {4'b0, cfg.irq_limit_us}) begin
        kind = hpdq_pkg::KIND_FALL_LONG;
      end else begin
        kind = hpdq_pkg::KIND_FALL_SHORT;
      end
    end
  end

  // The very first sample only seeds the previous level.
  assign cmd_push  = accept && started;
  assign cmd.level = hpd_level;
  assign cmd.kind  = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      prev_level <= 1'b0;
      edge_age   <= '0;
    end else if (accept) begin
      started <= 1'b1;
      if (!started || is_edge) begin
        prev_level <= hpd_level;
        edge_age   <= '0;
      end else begin
        edge_age <= age;
      end
    end
  end

endmodule

// ----- sv/hpdq_cmd_fifo.sv -----
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpdq_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hpdq_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           pop_valid,
  output hpdq_pkg::cmd_t pop_cmd,
  input  logic           pop
);

  hpdq_pkg::cmd_t                   slots [hpdq_pkg::CMD_DEPTH];
  logic [hpdq_pkg::CMD_PTR_W-1:0]   wp;
  logic [hpdq_pkg::CMD_PTR_W-1:0]   rp;
  logic [hpdq_pkg::CMD_CNT_W-1:0]   count;
  logic                             do_pop;

  assign full      = count == hpdq_pkg::CMD_CNT_W'(hpdq_pkg::CMD_DEPTH);
  assign pop_valid = count != '0;
  assign pop_cmd   = slots[rp];
  assign do_pop    = pop && pop_valid;

  function automatic logic [hpdq_pkg::CMD_PTR_W-1:0] ptr_inc(
    input logic [hpdq_pkg::CMD_PTR_W-1:0] p);
    return (p == hpdq_pkg::CMD_PTR_W'(hpdq_pkg::CMD_DEPTH - 1)) ? '0
                                                                : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= ptr_inc(wp);
      end
      if (do_pop) begin
        rp <= ptr_inc(rp);
      end
      count <= count + hpdq_pkg::CMD_CNT_W'(push) - hpdq_pkg::CMD_CNT_W'(do_pop);
    end
  end

  `ASSERT_ALWAYS(a_cmd_count_bound, count <= hpdq_pkg::CMD_CNT_W'(hpdq_pkg::CMD_DEPTH))

endmodule

// ----- sv/hpdq_back.sv -----
// Back end: event ring, level and send timers, and the result buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hpdq_back #(
  parameter int RING_SLOTS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  hpdq_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  hpdq_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     report_event,
  output logic           from_level_timer,
  output logic           last
);

  localparam int IDX_W = $clog2(RING_SLOTS);

  logic [1:0]                     ring [RING_SLOTS];
  logic [1:0]                     ring_next [RING_SLOTS];
  logic [IDX_W-1:0]               head, head_next;
  logic [IDX_W-1:0]               tail, tail_next;
  logic [1:0]                     newest, newest_next;
  logic [1:0]                     reported, reported_next;
  logic [hpdq_pkg::CFG_W-1:0]     ltimer, ltimer_next;
  logic                           larmed, larmed_next;
  logic [hpdq_pkg::CFG_W-1:0]     stimer, stimer_next;
  logic                           sarmed, sarmed_next;

  logic                           clear_en;
  logic                           put_a_en;
  logic [1:0]                     put_a_ev;
  logic                           launch_en;
  logic [1:0]                     launch_ev;
  logic                           arm_level;
  logic                           was_empty;
  logic [1:0]                     pre_ev;
  logic                           lv_emit;
  logic [1:0]                     lv_ev;
  logic                           q_emit;
  logic [1:0]                     take_ev;

  hpdq_pkg::res_t                 obuf [hpdq_pkg::OUT_DEPTH];
  logic [hpdq_pkg::OUT_PTR_W-1:0] owp, orp;
  logic [hpdq_pkg::OUT_CNT_W-1:0] ocount;
  logic [hpdq_pkg::OUT_CNT_W-1:0] push_n;
  logic                           out_pop;
  hpdq_pkg::res_t                 res0, res1;

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(RING_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [hpdq_pkg::OUT_PTR_W-1:0] obuf_inc(
    input logic [hpdq_pkg::OUT_PTR_W-1:0] p);
    return (p == hpdq_pkg::OUT_PTR_W'(hpdq_pkg::OUT_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // A command is taken only when the result buffer can absorb two beats.
  assign cmd_pop = cmd_valid && (ocount <= hpdq_pkg::OUT_CNT_W'(1));

  // Edge decode: what the edge does to the ring and the level timer.
  always_comb begin
    clear_en  = 1'b0;
    put_a_en  = 1'b0;
    put_a_ev  = hpdq_pkg::EV_NONE;
    launch_en = 1'b0;
    launch_ev = hpdq_pkg::EV_NONE;
    arm_level = 1'b0;
    pre_ev    = (head != tail) ? newest : reported;
    unique case (cmd.kind)
      hpdq_pkg::KIND_NONE: begin
      end
      hpdq_pkg::KIND_GLITCH: begin
        arm_level = 1'b1;
      end
      hpdq_pkg::KIND_IRQ: begin
        if (pre_ev == hpdq_pkg::EV_LOW) begin
          clear_en = 1'b1;
          put_a_en = 1'b1;
          put_a_ev = hpdq_pkg::EV_HIGH;
        end else if (head != tail && head != ring_inc(tail)) begin
          // More than one queued: keep only the newest.
          clear_en = 1'b1;
          put_a_en = 1'b1;
          put_a_ev = pre_ev;
        end
        launch_en = 1'b1;
        launch_ev = hpdq_pkg::EV_IRQ;
      end
      hpdq_pkg::KIND_LONG_LOW: begin
        clear_en  = 1'b1;
        launch_en = 1'b1;
        launch_ev = hpdq_pkg::EV_LOW;
        arm_level = 1'b1;
      end
      hpdq_pkg::KIND_FALL_SHORT: begin
        arm_level = 1'b1;
      end
      hpdq_pkg::KIND_FALL_LONG: begin
        launch_en = 1'b1;
        launch_ev = hpdq_pkg::EV_HIGH;
        arm_level = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Per-tick state update: ring writes, level timer, then send timer.
  always_comb begin
    ring_next     = ring;
    head_next     = head;
    tail_next     = tail;
    newest_next   = newest;
    reported_next = reported;
    ltimer_next   = ltimer;
    larmed_next   = larmed;
    stimer_next   = stimer;
    sarmed_next   = sarmed;
    was_empty     = 1'b0;
    lv_emit       = 1'b0;
    lv_ev         = cmd.level ? hpdq_pkg::EV_HIGH : hpdq_pkg::EV_LOW;
    q_emit        = 1'b0;
    take_ev       = hpdq_pkg::EV_NONE;

    if (cmd.kind != hpdq_pkg::KIND_NONE) begin
      larmed_next = 1'b0;
      ltimer_next = '0;
    end
    if (clear_en) begin
      head_next = tail_next;
    end
    if (put_a_en) begin
      ring_next[head_next] = put_a_ev;
      newest_next          = put_a_ev;
      head_next            = ring_inc(head_next);
      if (head_next == tail_next) begin
        tail_next = ring_inc(tail_next);
      end
    end
    if (launch_en) begin
      was_empty            = head_next == tail_next;
      ring_next[head_next] = launch_ev;
      newest_next          = launch_ev;
      head_next            = ring_inc(head_next);
      if (head_next == tail_next) begin
        tail_next = ring_inc(tail_next);
      end
      if (was_empty || !sarmed_next) begin
        stimer_next = '0;
        sarmed_next = 1'b1;
      end
    end
    if (arm_level) begin
      ltimer_next = cfg.level_debounce_us;
      larmed_next = 1'b1;
    end

    if (larmed_next) begin
      if (ltimer_next == '0) begin
        larmed_next = 1'b0;
        if (lv_ev != reported_next) begin
          reported_next = lv_ev;
          lv_emit       = 1'b1;
        end
      end else begin
        ltimer_next = ltimer_next - 1'b1;
      end
    end

    if (sarmed_next) begin
      if (stimer_next == '0) begin
        sarmed_next = 1'b0;
        q_emit      = 1'b1;
        if (head_next != tail_next) begin
          take_ev   = ring_next[tail_next];
          tail_next = ring_inc(tail_next);
        end
        reported_next = take_ev;
        if (head_next != tail_next) begin
          stimer_next = (cfg.queue_gap_us != '0) ? cfg.queue_gap_us - 1'b1 : '0;
          sarmed_next = 1'b1;
        end
      end else begin
        stimer_next = stimer_next - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      ring   <= ring_next;
      newest <= newest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      reported <= hpdq_pkg::EV_NONE;
      ltimer   <= '0;
      larmed   <= 1'b0;
      stimer   <= '0;
      sarmed   <= 1'b0;
    end else if (cmd_pop) begin
      head     <= head_next;
      tail     <= tail_next;
      reported <= reported_next;
      ltimer   <= ltimer_next;
      larmed   <= larmed_next;
      stimer   <= stimer_next;
      sarmed   <= sarmed_next;
    end
  end

  // Result buffer: the level-timer report goes first, then the queue report.
  assign res1.ev         = take_ev;
  assign res1.from_level = 1'b0;
  assign res1.last       = 1'b1;
  assign res0.ev         = lv_emit ? lv_ev : take_ev;
  assign res0.from_level = lv_emit;
  assign res0.last       = !(lv_emit && q_emit);
  assign push_n = cmd_pop ? (hpdq_pkg::OUT_CNT_W'(lv_emit) + hpdq_pkg::OUT_CNT_W'(q_emit))
                          : '0;

  assign out_valid        = ocount != '0;
  assign out_pop          = out_valid && !out_stall;
  assign report_event     = obuf[orp].ev;
  assign from_level_timer = obuf[orp].from_level;
  assign last             = obuf[orp].last;

  always_ff @(posedge clk) begin
    if (push_n != '0) begin
      obuf[owp] <= res0;
    end
    if (push_n == hpdq_pkg::OUT_CNT_W'(2)) begin
      obuf[obuf_inc(owp)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp    <= '0;
      orp    <= '0;
      ocount <= '0;
    end else begin
      if (push_n == hpdq_pkg::OUT_CNT_W'(1)) begin
        owp <= obuf_inc(owp);
      end else if (push_n == hpdq_pkg::OUT_CNT_W'(2)) begin
        owp <= obuf_inc(obuf_inc(owp));
      end
      if (out_pop) begin
        orp <= obuf_inc(orp);
      end
      ocount <= ocount + push_n - hpdq_pkg::OUT_CNT_W'(out_pop);
    end
  end

  // A pending transmission always has something queued behind it.
  `ASSERT_IMPLIES(a_send_has_entry, sarmed, head != tail)
  `ASSERT_ALWAYS(a_obuf_bound, ocount <= hpdq_pkg::OUT_CNT_W'(hpdq_pkg::OUT_DEPTH))

endmodule
